/* sv/bist_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded integer set table package
// Shared types and codes for the set table cells and the top level.
// ----------------------------------------------------------------------------
package bist_pkg;

	// Width of one stored element.
	localparam int unsigned ELEM_W = 32;

	// Width of the capacity register and of the reported element count.
	localparam int unsigned CAP_W = 7;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Operation codes carried on the input tuser field.
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic [ELEM_W-1:0] key;
		logic              shift_en;
	} cell_ctl_t;

endpackage

/* sv/bist_cell.sv */
// ----------------------------------------------------------------------------
// Set table cell
// Holds one element, compares it with the search key when the scan token
// sits here, and takes its upper neighbor's element while a remove closes
// the gap left by the removed value.
// ----------------------------------------------------------------------------
module bist_cell (
	input  logic                           clk,
	input  bist_pkg::cell_ctl_t            ctl,
	input  logic                           tok,      // scan token at this cell
	input  logic                           tok_up,   // scan token at the upper neighbor
	input  logic [bist_pkg::ELEM_W-1:0]    elem_up,  // element of the upper neighbor
	input  logic                           wr_sel,   // append the key into this cell
	output logic [bist_pkg::ELEM_W-1:0]    elem,
	output logic                           hit
);

	logic [bist_pkg::ELEM_W-1:0] elem_q;

	// Element storage: an append writes the key, a remove shifts down by one.
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			elem_q <= ctl.key;
		end else if (ctl.shift_en && tok_up) begin
			elem_q <= elem_up;
		end
	end

	// Compare only while the token is here.
	assign hit  = tok && (elem_q == ctl.key);
	assign elem = elem_q;

endmodule

/* sv/bounded_integer_set_table_unit.sv */
// ----------------------------------------------------------------------------
// Bounded integer set table unit
// Fixed-capacity set of signed 32-bit integers kept in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_tvalid/s_tready with the operation on
//   s_tuser (add, remove, query, clear) and the value on s_tdata. Each input
//   transaction gives exactly one result transaction on m_tvalid/m_tready.
//   The capacity register is written on cfg_valid/cfg_ready, which is always
//   ready; write it only while the unit is idle.
// Timing:
//   A scan token walks the cells one per cycle across the held elements;
//   once the scan ends, the item's result is loaded into the output register.
//   A remove shifts later elements down behind the token in the same pass.
//   One item is in work at a time; the next one is accepted while a result
//   still waits in the output register.
// Reset and stall:
//   Reset empties the set and sets the capacity to 64. When the receiver
//   stalls, the finished item holds in its last step until the output
//   register frees; no result is dropped.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] was_member, [1] changed, [8:2] element_count,
	                               // [9] is_full, [15:10] zero padding
	// Capacity register write.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > bist_pkg::CAP_W) ? CW : bist_pkg::CAP_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	bist_pkg::op_t                 op_q;
	logic [bist_pkg::ELEM_W-1:0]   key_q;
	logic                          found_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 idx_q;
	logic [DEPTH-1:0]              tok_q;
	logic [bist_pkg::CAP_W-1:0]    cap_q;
	logic                          m_tvalid_q;
	logic [15:0]                   m_tdata_q;

	bist_pkg::cell_ctl_t           ctl;
	logic [bist_pkg::ELEM_W-1:0]   elem [DEPTH];
	logic [DEPTH-1:0]              hit;
	logic [DEPTH-1:0]              wr_sel;
	logic                          in_fire;
	logic                          scan_live;
	logic                          out_free;
	logic                          finish;
	logic [CMPW-1:0]               cap_eff;
	logic                          add_ok;
	logic                          rem_ok;
	logic [CW-1:0]                 count_nxt;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;

	// The token is over a held element while its index is below the count.
	assign scan_live = (state_q == ST_SCAN) && (idx_q != count_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign finish    = (state_q == ST_DONE) && out_free;

	// Effective capacity saturates at the built depth.
	assign cap_eff = (CMPW'(cap_q) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_q);

	// Outcome of the finished item.
	assign add_ok = (op_q == bist_pkg::OP_ADD) && !found_q && (CMPW'(count_q) < cap_eff);
	assign rem_ok = (op_q == bist_pkg::OP_REMOVE) && found_q;

	always_comb begin
		case (op_q)
			bist_pkg::OP_ADD:    count_nxt = add_ok ? count_q + CW'(1) : count_q;
			bist_pkg::OP_REMOVE: count_nxt = rem_ok ? count_q - CW'(1) : count_q;
			bist_pkg::OP_CLEAR:  count_nxt = '0;
			default:             count_nxt = count_q;
		endcase
	end

	// Broadcast controls: shifting starts one cell past the removed value.
	assign ctl.key      = key_q;
	assign ctl.shift_en = scan_live && found_q && (op_q == bist_pkg::OP_REMOVE);

	// Row of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                         tok_up;
		logic [bist_pkg::ELEM_W-1:0]  elem_up;

		if (i + 1 < DEPTH) begin : g_up
			assign tok_up  = tok_q[i+1];
			assign elem_up = elem[i+1];
		end else begin : g_top
			assign tok_up  = 1'b0;
			assign elem_up = '0;
		end

		assign wr_sel[i] = finish && add_ok && (count_q == CW'(i));

		bist_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.tok     (tok_q[i]),
			.tok_up  (tok_up),
			.elem_up (elem_up),
			.wr_sel  (wr_sel[i]),
			.elem    (elem[i]),
			.hit     (hit[i])
		);
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bist_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Item registers, loaded when a transaction is accepted.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= s_tdata;
			op_q  <= bist_pkg::op_t'(s_tuser);
		end
	end

	// Sequencer: accept, scan the held elements, then commit and report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
			tok_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
						found_q <= 1'b0;
						idx_q   <= '0;
						tok_q   <= DEPTH'(1);
					end
				end
				ST_SCAN: begin
					if (scan_live) begin
						found_q <= found_q || (|hit);
						idx_q   <= idx_q + CW'(1);
						tok_q   <= tok_q << 1;
					end else begin
						state_q <= ST_DONE;
						tok_q   <= '0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						count_q <= count_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {6'd0,
				(CMPW'(count_nxt) >= cap_eff),
				bist_pkg::CAP_W'(count_nxt),
				add_ok || rem_ok,
				found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
